// File: rtl/cpdp_pkg.sv
`default_nettype none
package cpdp_pkg;

   // field widths
   localparam int TARGET_W = 34;
   localparam int REF_W    = 30;
   localparam int DIV_W    = 10;
   localparam int VCO_W    = 34;
   localparam int N2_W     = 8;
   localparam int N1_W     = 19;
   localparam int FRAC_W   = 32;
   localparam int NUM_W    = VCO_W + DIV_W;   // vco * chan_div_first
   localparam int DEN_W    = N2_W + REF_W;    // n2 * ref_freq_first
   localparam int THR_W    = 36;
   localparam int CSR_IDX_W = 2;

   localparam int NUM_DIVS = 17;

   // request queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;
   localparam int QUEUE_CW    = 3;

   localparam logic [REF_W-1:0]  REF_FREQ_RESET = 30'd100000000;
   localparam logic [DIV_W-1:0]  CHAN_DIV_RESET = 10'd96;
   localparam logic [N1_W-1:0]   N1_MAX         = 19'd524287;
   localparam logic [FRAC_W-1:0] FRAC_MAX       = 32'hFFFF_FFFF;
   localparam logic [VCO_W-1:0]  VCO_MIN        = 34'd7500000000;

   localparam logic [127:0] SCALE_NUM      = 128'd12075858607;
   localparam logic [127:0] HALF_SCALE_DEN = 128'd500000000000000000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REF_FREQ_FIRST = 2'd0,
      CSR_CHAN_DIV_FIRST = 2'd1
   } csr_index_type;

   typedef logic [TARGET_W-1:0] thresh_arr_type [NUM_DIVS];
   typedef logic [DIV_W-1:0]    divval_arr_type [NUM_DIVS];

   localparam thresh_arr_type DIV_THRESH = '{
      34'd7500000000, 34'd3750000000, 34'd1875000000, 34'd1250000000,
      34'd937500000,  34'd625000000,  34'd468750000,  34'd312500000,
      34'd234375000,  34'd156250000,  34'd117187500,  34'd78125000,
      34'd58593750,   34'd39062500,   34'd29296875,   34'd19531250,
      34'd9765625
   };

   localparam divval_arr_type DIV_VALUE = '{
      10'd1, 10'd2, 10'd4, 10'd6, 10'd8, 10'd12, 10'd16, 10'd24, 10'd32,
      10'd48, 10'd64, 10'd96, 10'd128, 10'd192, 10'd256, 10'd384, 10'd768
   };

   // n2 >= k exactly when vco >= ceil((2k-1) * 5e17 / 12075858607)
   typedef logic [THR_W-1:0] n2_thr_type [2**N2_W];

   function automatic n2_thr_type build_n2_thresh();
      n2_thr_type   t;
      logic [127:0] num;
      t[0] = '0;
      for (int k = 1; k < 2**N2_W; k++) begin
         num  = 128'(2 * k - 1) * HALF_SCALE_DEN;
         t[k] = THR_W'((num + SCALE_NUM - 128'd1) / SCALE_NUM);
      end
      return t;
   endfunction

   localparam n2_thr_type N2_THRESH = build_n2_thresh();

   typedef struct packed {
      logic             oor;
      logic [DIV_W-1:0] cd2;
      logic [VCO_W-1:0] vco;
   } plan_type;

   typedef struct packed {
      logic [DIV_W-1:0]  cd2;
      logic [VCO_W-1:0]  vco;
      logic [N2_W-1:0]   n2;
      logic [N1_W-1:0]   n1;
      logic [FRAC_W-1:0] frac;
      logic              oor;
   } result_type;

endpackage
`default_nettype wire

// File: rtl/cpdp_front.sv
`default_nettype none
module cpdp_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [cpdp_pkg::TARGET_W-1:0]    req_target,
   output logic                             out_valid,
   input  logic                             out_ready,
   output cpdp_pkg::plan_type               out_plan
);

   logic                            front_en;
   logic                            c_valid_ff;
   logic [cpdp_pkg::TARGET_W-1:0]   c_target_ff;
   logic [cpdp_pkg::DIV_W-1:0]      c_cd2_ff;
   logic                            c_oor_ff;
   logic [cpdp_pkg::DIV_W-1:0]      c_cd2_in;
   logic                            c_oor_in;
   logic [cpdp_pkg::NUM_W-1:0]      vco_full;
   logic                            p_valid_ff;
   cpdp_pkg::plan_type              p_plan_ff;
   cpdp_pkg::plan_type              p_plan_in;

   assign front_en  = !p_valid_ff || out_ready;
   assign req_ready = front_en;

   // first threshold met wins
   always_comb begin
      c_cd2_in = '0;
      c_oor_in = 1'b1;
      for (int i = cpdp_pkg::NUM_DIVS - 1; i >= 0; i--) begin
         if (req_target >= cpdp_pkg::DIV_THRESH[i]) begin
            c_cd2_in = cpdp_pkg::DIV_VALUE[i];
            c_oor_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         p_valid_ff <= 1'b0;
      end else if (front_en) begin
         c_valid_ff <= req_valid;
         p_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (front_en) begin
         c_target_ff <= req_target;
         c_cd2_ff    <= c_cd2_in;
         c_oor_ff    <= c_oor_in;
         p_plan_ff   <= p_plan_in;
      end
   end

   assign vco_full = cpdp_pkg::NUM_W'(c_target_ff) * cpdp_pkg::NUM_W'(c_cd2_ff);

   always_comb begin
      p_plan_in.oor = c_oor_ff;
      p_plan_in.cd2 = c_cd2_ff;
      p_plan_in.vco = vco_full[cpdp_pkg::VCO_W-1:0];
   end

   assign out_valid = p_valid_ff;
   assign out_plan  = p_plan_ff;

endmodule
`default_nettype wire

// File: rtl/cpdp_queue.sv
`default_nettype none
module cpdp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  cpdp_pkg::plan_type   push_plan,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output cpdp_pkg::plan_type   pop_plan
);

   cpdp_pkg::plan_type               mem_ff [cpdp_pkg::QUEUE_DEPTH];
   logic [cpdp_pkg::QUEUE_AW-1:0]    wr_ptr_ff;
   logic [cpdp_pkg::QUEUE_AW-1:0]    rd_ptr_ff;
   logic [cpdp_pkg::QUEUE_CW-1:0]    count_ff;
   logic                             do_push;
   logic                             do_pop;

   assign push_ready = (count_ff != cpdp_pkg::QUEUE_CW'(cpdp_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_plan   = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (do_push && !do_pop)      count_ff <= count_ff + 1'b1;
         else if (do_pop && !do_push) count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_plan;
   end

endmodule
`default_nettype wire

// File: rtl/cpdp_back.sv
`default_nettype none
module cpdp_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  cpdp_pkg::plan_type             in_plan,
   input  logic [cpdp_pkg::REF_W-1:0]     ref_freq,
   input  logic [cpdp_pkg::DIV_W-1:0]     chan_div,
   output logic                           out_valid,
   input  logic                           out_ready,
   output cpdp_pkg::result_type           out_result
);

   localparam int SW  = cpdp_pkg::N2_W;     // search stages
   localparam int DW  = cpdp_pkg::N1_W;     // integer divide stages
   localparam int FW  = cpdp_pkg::FRAC_W;   // fraction divide stages
   localparam int DNW = cpdp_pkg::DEN_W;

   logic en;

   // n2 search
   logic               a_valid_ff [SW];
   cpdp_pkg::plan_type a_plan_ff  [SW];
   logic [SW-1:0]      a_acc_ff   [SW];

   // products
   logic                       m_valid_ff;
   cpdp_pkg::plan_type         m_plan_ff;
   logic [SW-1:0]              m_n2_ff;
   logic [cpdp_pkg::NUM_W-1:0] m_num_ff;
   logic [DNW-1:0]             m_den_ff;

   // saturation check and divider seed
   logic               z_valid_ff;
   cpdp_pkg::plan_type z_plan_ff;
   logic [SW-1:0]      z_n2_ff;
   logic [DNW-1:0]     z_den_ff;
   logic               z_sat_ff;
   logic [DNW-1:0]     z_rem_ff;
   logic [DW-1:0]      z_lo_ff;
   logic               z_sat_in;

   // integer quotient
   logic               d_valid_ff [DW];
   cpdp_pkg::plan_type d_plan_ff  [DW];
   logic [SW-1:0]      d_n2_ff    [DW];
   logic [DNW-1:0]     d_den_ff   [DW];
   logic               d_sat_ff   [DW];
   logic [DNW-1:0]     d_rem_ff   [DW];
   logic [DW-1:0]      d_q_ff     [DW];
   logic [DW-1:0]      d_lo_ff    [DW];

   // fraction dividend
   logic               x_valid_ff;
   cpdp_pkg::plan_type x_plan_ff;
   logic [SW-1:0]      x_n2_ff;
   logic               x_sat_ff;
   logic [DW-1:0]      x_q_ff;
   logic [DNW:0]       x_d2_ff;
   logic [DNW:0]       x_r_ff;
   logic [FW-1:0]      x_lo_ff;
   logic [71:0]        x_wide;

   // fraction quotient
   logic               f_valid_ff [FW];
   cpdp_pkg::plan_type f_plan_ff  [FW];
   logic [SW-1:0]      f_n2_ff    [FW];
   logic               f_sat_ff   [FW];
   logic [DW-1:0]      f_q_ff     [FW];
   logic [DNW:0]       f_d2_ff    [FW];
   logic [DNW:0]       f_r_ff     [FW];
   logic [FW-1:0]      f_lo_ff    [FW];
   logic [FW-1:0]      f_frac_ff  [FW];

   logic                 out_valid_ff;
   cpdp_pkg::result_type out_result_ff;
   cpdp_pkg::result_type out_result_in;

   assign en       = !out_valid_ff || out_ready;
   assign in_ready = en;

   genvar i;

   // binary search on the n2 threshold table, one bit per stage
   for (i = 0; i < SW; i++) begin : g_search
      logic               src_valid;
      cpdp_pkg::plan_type src_plan;
      logic [SW-1:0]      src_acc;
      logic [SW-1:0]      cand;
      logic [SW-1:0]      acc_in;
      if (i == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_plan  = in_plan;
         assign src_acc   = '0;
      end else begin : g_next
         assign src_valid = a_valid_ff[i-1];
         assign src_plan  = a_plan_ff[i-1];
         assign src_acc   = a_acc_ff[i-1];
      end
      assign cand   = src_acc | (SW'(1) << (SW - 1 - i));
      assign acc_in = (cpdp_pkg::N2_THRESH[cand] <= {2'b00, src_plan.vco}) ? cand : src_acc;
      always_ff @(posedge clock) begin
         if (reset) a_valid_ff[i] <= 1'b0;
         else if (en) a_valid_ff[i] <= src_valid;
      end
      always_ff @(posedge clock) begin
         if (en) begin
            a_plan_ff[i] <= src_plan;
            a_acc_ff[i]  <= acc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         z_valid_ff <= 1'b0;
         x_valid_ff <= 1'b0;
      end else if (en) begin
         m_valid_ff <= a_valid_ff[SW-1];
         z_valid_ff <= m_valid_ff;
         x_valid_ff <= d_valid_ff[DW-1];
      end
   end

   assign z_sat_in = (m_den_ff == '0) ||
                     ({13'd0, m_num_ff} >= {m_den_ff, 19'd0});

   assign x_wide = {1'b0, d_rem_ff[DW-1], 33'd0} - {33'd0, d_rem_ff[DW-1], 1'b0}
                 + {34'd0, d_den_ff[DW-1]};

   always_ff @(posedge clock) begin
      if (en) begin
         m_plan_ff <= a_plan_ff[SW-1];
         m_n2_ff   <= a_acc_ff[SW-1];
         m_num_ff  <= cpdp_pkg::NUM_W'(a_plan_ff[SW-1].vco) * cpdp_pkg::NUM_W'(chan_div);
         m_den_ff  <= DNW'(a_acc_ff[SW-1]) * DNW'(ref_freq);

         z_plan_ff <= m_plan_ff;
         z_n2_ff   <= m_n2_ff;
         z_den_ff  <= m_den_ff;
         z_sat_ff  <= z_sat_in;
         z_rem_ff  <= {13'd0, m_num_ff[cpdp_pkg::NUM_W-1:DW]};
         z_lo_ff   <= m_num_ff[DW-1:0];

         x_plan_ff <= d_plan_ff[DW-1];
         x_n2_ff   <= d_n2_ff[DW-1];
         x_sat_ff  <= d_sat_ff[DW-1];
         x_q_ff    <= d_q_ff[DW-1];
         x_d2_ff   <= {d_den_ff[DW-1], 1'b0};
         x_r_ff    <= x_wide[70:32];
         x_lo_ff   <= x_wide[31:0];
      end
   end

   // restoring divide, integer part
   for (i = 0; i < DW; i++) begin : g_idiv
      logic               src_valid;
      cpdp_pkg::plan_type src_plan;
      logic [SW-1:0]      src_n2;
      logic [DNW-1:0]     src_den;
      logic               src_sat;
      logic [DNW-1:0]     src_rem;
      logic [DW-1:0]      src_q;
      logic [DW-1:0]      src_lo;
      logic [DNW:0]       trial;
      logic               ge;
      logic [DNW-1:0]     rem_in;
      if (i == 0) begin : g_first
         assign src_valid = z_valid_ff;
         assign src_plan  = z_plan_ff;
         assign src_n2    = z_n2_ff;
         assign src_den   = z_den_ff;
         assign src_sat   = z_sat_ff;
         assign src_rem   = z_rem_ff;
         assign src_q     = '0;
         assign src_lo    = z_lo_ff;
      end else begin : g_next
         assign src_valid = d_valid_ff[i-1];
         assign src_plan  = d_plan_ff[i-1];
         assign src_n2    = d_n2_ff[i-1];
         assign src_den   = d_den_ff[i-1];
         assign src_sat   = d_sat_ff[i-1];
         assign src_rem   = d_rem_ff[i-1];
         assign src_q     = d_q_ff[i-1];
         assign src_lo    = d_lo_ff[i-1];
      end
      assign trial  = {src_rem, src_lo[DW-1]};
      assign ge     = (trial >= {1'b0, src_den});
      assign rem_in = ge ? DNW'(trial - {1'b0, src_den}) : trial[DNW-1:0];
      always_ff @(posedge clock) begin
         if (reset) d_valid_ff[i] <= 1'b0;
         else if (en) d_valid_ff[i] <= src_valid;
      end
      always_ff @(posedge clock) begin
         if (en) begin
            d_plan_ff[i] <= src_plan;
            d_n2_ff[i]   <= src_n2;
            d_den_ff[i]  <= src_den;
            d_sat_ff[i]  <= src_sat;
            d_rem_ff[i]  <= rem_in;
            d_q_ff[i]    <= {src_q[DW-2:0], ge};
            d_lo_ff[i]   <= {src_lo[DW-2:0], 1'b0};
         end
      end
   end

   // restoring divide, rounded fraction over twice the denominator
   for (i = 0; i < FW; i++) begin : g_fdiv
      logic               src_valid;
      cpdp_pkg::plan_type src_plan;
      logic [SW-1:0]      src_n2;
      logic               src_sat;
      logic [DW-1:0]      src_q;
      logic [DNW:0]       src_d2;
      logic [DNW:0]       src_r;
      logic [FW-1:0]      src_lo;
      logic [FW-1:0]      src_frac;
      logic [DNW+1:0]     trial;
      logic               ge;
      logic [DNW:0]       r_in;
      if (i == 0) begin : g_first
         assign src_valid = x_valid_ff;
         assign src_plan  = x_plan_ff;
         assign src_n2    = x_n2_ff;
         assign src_sat   = x_sat_ff;
         assign src_q     = x_q_ff;
         assign src_d2    = x_d2_ff;
         assign src_r     = x_r_ff;
         assign src_lo    = x_lo_ff;
         assign src_frac  = '0;
      end else begin : g_next
         assign src_valid = f_valid_ff[i-1];
         assign src_plan  = f_plan_ff[i-1];
         assign src_n2    = f_n2_ff[i-1];
         assign src_sat   = f_sat_ff[i-1];
         assign src_q     = f_q_ff[i-1];
         assign src_d2    = f_d2_ff[i-1];
         assign src_r     = f_r_ff[i-1];
         assign src_lo    = f_lo_ff[i-1];
         assign src_frac  = f_frac_ff[i-1];
      end
      assign trial = {src_r, src_lo[FW-1]};
      assign ge    = (trial >= {1'b0, src_d2});
      assign r_in  = ge ? (DNW+1)'(trial - {1'b0, src_d2}) : trial[DNW:0];
      always_ff @(posedge clock) begin
         if (reset) f_valid_ff[i] <= 1'b0;
         else if (en) f_valid_ff[i] <= src_valid;
      end
      always_ff @(posedge clock) begin
         if (en) begin
            f_plan_ff[i] <= src_plan;
            f_n2_ff[i]   <= src_n2;
            f_sat_ff[i]  <= src_sat;
            f_q_ff[i]    <= src_q;
            f_d2_ff[i]   <= src_d2;
            f_r_ff[i]    <= r_in;
            f_lo_ff[i]   <= {src_lo[FW-2:0], 1'b0};
            f_frac_ff[i] <= {src_frac[FW-2:0], ge};
         end
      end
   end

   always_comb begin
      out_result_in.cd2  = f_plan_ff[FW-1].cd2;
      out_result_in.vco  = f_plan_ff[FW-1].vco;
      out_result_in.n2   = f_n2_ff[FW-1];
      out_result_in.n1   = f_q_ff[FW-1];
      out_result_in.frac = f_frac_ff[FW-1];
      out_result_in.oor  = 1'b0;
      if (f_plan_ff[FW-1].oor) begin
         out_result_in     = '0;
         out_result_in.oor = 1'b1;
      end else if (f_sat_ff[FW-1]) begin
         out_result_in.n1   = cpdp_pkg::N1_MAX;
         out_result_in.frac = cpdp_pkg::FRAC_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (en) out_valid_ff <= f_valid_ff[FW-1];
   end

   always_ff @(posedge clock) begin
      if (en) out_result_ff <= out_result_in;
   end

   assign out_valid  = out_valid_ff;
   assign out_result = out_result_ff;

endmodule
`default_nettype wire

// File: rtl/cascaded_pll_divider_plan.sv
// Channel  Handshake            Payload
// req      req_valid/req_ready  req_target_freq_hz (34b, Hz)
// rsp      rsp_valid/rsp_ready  chan_div_second, vco_freq_second, n_int_second,
//                               n_int_first, n_frac_first, out_of_range
// csr      csr_valid/csr_ready  csr_index (2b), csr_wdata (30b)
//
// One request per cycle sustained while rsp is not stalled; pipeline: 2 front stages,
// queue, 8 search stages, 2 product/check stages, 19 + 1 + 32 divide stages,
// output register. The divider stages set the depth.
// Synchronous active-high reset clears valids, queue pointers and the csr
// registers to their defaults; no clearing pass.
// rsp stall freezes the back pipeline; the 4-deep queue absorbs the front.
`default_nettype none
module cascaded_pll_divider_plan (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [cpdp_pkg::TARGET_W-1:0]       req_target_freq_hz,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [cpdp_pkg::DIV_W-1:0]          rsp_chan_div_second,
   output logic [cpdp_pkg::VCO_W-1:0]          rsp_vco_freq_second,
   output logic [cpdp_pkg::N2_W-1:0]           rsp_n_int_second,
   output logic [cpdp_pkg::N1_W-1:0]           rsp_n_int_first,
   output logic [cpdp_pkg::FRAC_W-1:0]         rsp_n_frac_first,
   output logic                                rsp_out_of_range,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cpdp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cpdp_pkg::REF_W-1:0]          csr_wdata
);

   // csr registers
   logic [cpdp_pkg::REF_W-1:0] ref_freq_ff;
   logic [cpdp_pkg::DIV_W-1:0] chan_div_ff;

   // front -> queue -> back
   logic                 fq_valid;
   logic                 fq_ready;
   cpdp_pkg::plan_type   fq_plan;
   logic                 qb_valid;
   logic                 qb_ready;
   cpdp_pkg::plan_type   qb_plan;
   cpdp_pkg::result_type result;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_freq_ff <= cpdp_pkg::REF_FREQ_RESET;
         chan_div_ff <= cpdp_pkg::CHAN_DIV_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            cpdp_pkg::CSR_REF_FREQ_FIRST: ref_freq_ff <= csr_wdata;
            cpdp_pkg::CSR_CHAN_DIV_FIRST: chan_div_ff <= csr_wdata[cpdp_pkg::DIV_W-1:0];
            default: ;
         endcase
      end
   end

   // classify target, pick divider, form vco
   cpdp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_target (req_target_freq_hz),
      .out_valid  (fq_valid),
      .out_ready  (fq_ready),
      .out_plan   (fq_plan)
   );

   cpdp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_plan  (fq_plan),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_plan   (qb_plan)
   );

   // n2 search, first-synth ratio divide, rounding
   cpdp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (qb_valid),
      .in_ready   (qb_ready),
      .in_plan    (qb_plan),
      .ref_freq   (ref_freq_ff),
      .chan_div   (chan_div_ff),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_result (result)
   );

   assign rsp_chan_div_second = result.cd2;
   assign rsp_vco_freq_second = result.vco;
   assign rsp_n_int_second    = result.n2;
   assign rsp_n_int_first     = result.n1;
   assign rsp_n_frac_first    = result.frac;
   assign rsp_out_of_range    = result.oor;

endmodule
`default_nettype wire

// File: rtl/cpdp_checker.sv
`default_nettype none
module cpdp_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [cpdp_pkg::DIV_W-1:0]          rsp_chan_div_second,
   input logic [cpdp_pkg::VCO_W-1:0]          rsp_vco_freq_second,
   input logic [cpdp_pkg::N2_W-1:0]           rsp_n_int_second,
   input logic [cpdp_pkg::N1_W-1:0]           rsp_n_int_first,
   input logic [cpdp_pkg::FRAC_W-1:0]         rsp_n_frac_first,
   input logic                                rsp_out_of_range
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_vco_freq_second)
         && $stable(rsp_n_frac_first) && $stable(rsp_n_int_first))
      else $error("rsp payload moved while stalled");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |-> rsp_chan_div_second == '0
         && rsp_vco_freq_second == '0 && rsp_n_int_second == '0
         && rsp_n_int_first == '0 && rsp_n_frac_first == '0)
      else $error("out of range plan with nonzero fields");

   a_in_range_div: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_of_range |-> rsp_chan_div_second != '0
         && rsp_vco_freq_second >= cpdp_pkg::VCO_MIN)
      else $error("in range plan with bad divider or vco");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind cascaded_pll_divider_plan cpdp_checker u_cpdp_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_chan_div_second (rsp_chan_div_second),
   .rsp_vco_freq_second (rsp_vco_freq_second),
   .rsp_n_int_second    (rsp_n_int_second),
   .rsp_n_int_first     (rsp_n_int_first),
   .rsp_n_frac_first    (rsp_n_frac_first),
   .rsp_out_of_range    (rsp_out_of_range)
);
`default_nettype wire
